// File: hdl/address_region_table_assert.svh
// ----------------------------------------------------------------------------
// address_region_table_assert
// Assertion macros for the region table; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_TABLE_ASSERT_SVH
`define ADDRESS_REGION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define ART_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ART_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ART_ASSERT(lbl, ante, cons, msg)
`define ART_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared codes, entry layout and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int SLOT_W = 4;
	localparam int IN_W   = 184;
	localparam int OUT_W  = 160;

	// item kinds
	localparam logic [1:0] KIND_ADD       = 2'd0;
	localparam logic [1:0] KIND_FIND_ADDR = 2'd1;
	localparam logic [1:0] KIND_FIND_ID   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OVERLAP = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	localparam logic [7:0] SHARED_ID = 8'hFF;

	// one table entry, id in the low bits
	typedef struct packed {
		logic [15:0] tag;
		logic [63:0] end_addr;
		logic [63:0] start_addr;
		logic [7:0]  id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
		entry_t            ent;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic capture_hit;
		logic capture_miss;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table
// Region table with ordered add (overlap and duplicate-id check), address lookup and id lookup.
// Each result is captured into a result register and then moved to the output
// register, which drives m_tvalid; a hit ends the scan at its slot.
// Items are taken one at a time: s_tready is high only while idle, and the scan
// reads one table entry per cycle through the table RAM read port.
// Reset: arst_n clears the fill count and all control; table RAM is not swept.
// ----------------------------------------------------------------------------
module address_region_table #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// region_id[7:0], base[71:8], length[103:72], address[167:104],
	// handler_tag[183:168]
	input  logic [art_pkg::IN_W-1:0]   s_tdata,
	// kind[1:0]
	input  logic [1:0]                 s_tuser,
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// slot[3:0], found_id[11:4], found_start[75:12], found_end[139:76],
	// found_tag[155:140], zero[159:156]
	output logic [art_pkg::OUT_W-1:0]  m_tdata,
	// status[2:0]
	output logic [2:0]                 m_tuser
);
	import art_pkg::*;

	// command/status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle -> scan (one RAM read per cycle) -> done (wait for out reg)
	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: item regs, table RAM, compare, result and output registers;
	// the output register lets a new transfer in while a result waits
	art_datapath #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: accept, scan the table, capture the result, hand it to output.
// ----------------------------------------------------------------------------
module art_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  art_pkg::sts_t sts,
	output art_pkg::cmd_t cmd
);
	import art_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.hit) begin
					cmd.capture_hit = 1'b1;
					state_d         = ST_DONE;
				end else if (!sts.more) begin
					cmd.capture_miss = 1'b1;
					state_d          = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/art_datapath.sv
// ----------------------------------------------------------------------------
// art_datapath
// Item registers, scan pointer, entry compare, table RAM and output register.
// ----------------------------------------------------------------------------
`include "address_region_table_assert.svh"

module art_datapath #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  art_pkg::cmd_t              cmd,
	output art_pkg::sts_t              sts,
	input  logic [art_pkg::IN_W-1:0]   s_tdata,
	input  logic [1:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [art_pkg::OUT_W-1:0]  m_tdata,
	output logic [2:0]                 m_tuser
);
	import art_pkg::*;

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
		logic [IW+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, i};
		return w[SLOT_W-1:0];
	endfunction

	// input unpack
	logic [7:0]  in_id;
	logic [63:0] in_base;
	logic [31:0] in_len;
	logic [63:0] in_addr;
	logic [15:0] in_tag;

	assign in_id   = s_tdata[7:0];
	assign in_base = s_tdata[71:8];
	assign in_len  = s_tdata[103:72];
	assign in_addr = s_tdata[167:104];
	assign in_tag  = s_tdata[183:168];

	// item registers
	logic [1:0]  kind_q;
	logic [7:0]  id_q;
	logic [63:0] base_q;
	logic [63:0] end_q;
	logic [63:0] addr_q;
	logic [15:0] tag_q;
	logic        scan_en_q;

	// table state and scan pointer
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          chk_vld_q;
	logic [IW-1:0] chk_idx_q;

	logic    issue;
	logic    ram_re;
	logic    ram_we;
	entry_t  ent;
	entry_t  new_ent;
	logic    ovl;
	logic    dup;
	logic    match;
	logic [2:0] hit_status;

	result_t res_q;
	result_t out_q;
	logic    out_vld_q;

	assign issue  = scan_en_q && (idx_q < cnt_q);
	assign ram_re = cmd.step && issue;
	assign ram_we = cmd.capture_miss && (kind_q == KIND_ADD) && (cnt_q != CNT_MAX);

	assign new_ent.id         = id_q;
	assign new_ent.start_addr = base_q;
	assign new_ent.end_addr   = end_q;
	assign new_ent.tag        = tag_q;

	art_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_REGIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (new_ent),
		.re    (ram_re),
		.raddr (idx_q[IW-1:0]),
		.rdata (ent)
	);

	// entry compare on the word read last cycle
	always_comb begin
		ovl = (ent.start_addr == base_q) || (ent.end_addr == end_q)
			|| ((ent.start_addr > base_q) && (ent.start_addr < end_q))
			|| ((ent.end_addr > base_q) && (ent.end_addr < end_q))
			|| ((ent.start_addr < base_q) && (ent.end_addr > end_q))
			|| ((ent.start_addr > base_q) && (ent.end_addr < end_q));
		dup = (id_q != SHARED_ID) && (ent.id == id_q);
		hit_status = ST_OK;
		case (kind_q)
			KIND_ADD: begin
				match      = ovl || dup;
				hit_status = ovl ? ST_OVERLAP : ST_DUP;
			end
			KIND_FIND_ADDR: begin
				match = (addr_q >= ent.start_addr) && (addr_q <= ent.end_addr);
			end
			KIND_FIND_ID: begin
				match = (ent.id == id_q);
			end
			default: begin
				match = 1'b0;
			end
		endcase
	end

	assign sts.more     = scan_en_q && (issue || chk_vld_q);
	assign sts.hit      = chk_vld_q && match;
	assign sts.out_free = !out_vld_q || m_tready;

	// item capture, no reset on payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= s_tuser;
			id_q   <= in_id;
			base_q <= in_base;
			end_q  <= in_base + {32'd0, in_len};
			addr_q <= in_addr;
			tag_q  <= in_tag;
		end
		if (cmd.step) begin
			chk_idx_q <= idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_en_q <= ((s_tuser == KIND_ADD) && (cnt_q != CNT_MAX))
					|| (s_tuser == KIND_FIND_ADDR) || (s_tuser == KIND_FIND_ID);
				idx_q     <= '0;
				chk_vld_q <= 1'b0;
			end else if (cmd.step) begin
				chk_vld_q <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (ram_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (cmd.capture_hit) begin
			res_q.status <= hit_status;
			res_q.slot   <= to_slot(chk_idx_q);
			res_q.ent    <= ent;
		end else if (cmd.capture_miss) begin
			if ((kind_q == KIND_ADD) && (cnt_q != CNT_MAX)) begin
				res_q.status <= ST_OK;
				res_q.slot   <= to_slot(cnt_q[IW-1:0]);
				res_q.ent    <= new_ent;
			end else begin
				res_q.status <= (kind_q == KIND_ADD) ? ST_FULL : ST_NONE;
				res_q.slot   <= '0;
				res_q.ent    <= '0;
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{(OUT_W - ENTRY_W - SLOT_W){1'b0}}, out_q.ent, out_q.slot};

	`ART_ASSERT(a_wr_below_max, ram_we, cnt_q < CNT_MAX, "append with full table")
	`ART_ASSERT(a_rd_below_cnt, ram_re, idx_q < cnt_q, "read beyond fill count")
	`ART_ASSERT_NXT(a_cnt_by_write, !ram_we, $stable(cnt_q), "count moved without write")
	`ART_ASSERT(a_hit_on_check, cmd.capture_hit, chk_vld_q, "hit without a checked entry")

endmodule
